/* hw/rtl/satag_pkg.sv */
// Shared types, widths and helpers for the single-axis transpose address generator.
// No dependencies.
package satag_pkg;

  localparam int unsigned ADDR_W = 24;
  localparam int unsigned DIM_W  = 12;
  localparam int unsigned LEN_W  = DIM_W + 1;
  localparam int unsigned CFG_W  = 13;
  localparam int unsigned IDX_W  = 2;
  localparam int unsigned SETTLE_CYCLES = 2;
  localparam int unsigned SETTLE_W = 2;

  typedef enum logic [IDX_W-1:0] {
    REG_OUTER  = 2'd0,
    REG_AXIS   = 2'd1,
    REG_MIDDLE = 2'd2,
    REG_BLOCK  = 2'd3
  } reg_idx_e;

  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [DIM_W-1:0]  pos_t;
  typedef logic [LEN_W-1:0]  len_t;

  typedef struct packed {
    len_t  o_len;
    len_t  a_len;
    len_t  m_len;
    len_t  b_len;
    addr_t amb_stride;
    addr_t axis_step;
  } geom_t;

  typedef struct packed {
    addr_t source_index;
    addr_t dest_index;
    logic  last;
    logic  valid_res;
  } res_t;

  // zero acts as one, anything above 2^DIM_W saturates
  function automatic len_t eff_len(input logic [CFG_W-1:0] v);
    logic [31:0] cap;
    cap = 32'd1 << DIM_W;
    if (v == '0) begin
      return LEN_W'(1);
    end else if (32'(v) > cap) begin
      return LEN_W'(cap);
    end else begin
      return LEN_W'(v);
    end
  endfunction

endpackage

/* hw/rtl/satag_if.sv */
// Handshake channel interfaces: start/advance items, index-pair results, config writes.
// Depends on satag_pkg.
interface satag_in_if;
  logic valid;
  logic ready;
  logic start_req;
  modport source (output valid, output start_req, input ready);
  modport sink (input valid, input start_req, output ready);
endinterface

interface satag_out_if;
  logic                  valid;
  logic                  ready;
  satag_pkg::addr_t      source_index;
  satag_pkg::addr_t      dest_index;
  logic                  last;
  logic                  valid_res;
  modport source (output valid, output source_index, output dest_index, output last,
                  output valid_res, input ready);
  modport sink (input valid, input source_index, input dest_index, input last,
                input valid_res, output ready);
endinterface

interface satag_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [satag_pkg::IDX_W-1:0]       index;
  logic [satag_pkg::CFG_W-1:0]       data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

/* hw/rtl/satag_cfg.sv */
// Config registers (stored as effective lengths) and the derived address strides.
// After a write mb settles, then the strides from it. Depends on satag_pkg.
module satag_cfg (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        wr_en_i,
  input  logic [satag_pkg::IDX_W-1:0] wr_idx_i,
  input  logic [satag_pkg::CFG_W-1:0] wr_data_i,
  output satag_pkg::geom_t            geom_o,
  output logic                        settled_o
);

  satag_pkg::len_t  o_len_q, a_len_q, m_len_q, b_len_q;
  satag_pkg::addr_t mb_q, mb_d, amb_q, amb_d, step_q, step_d;
  logic [satag_pkg::SETTLE_W-1:0] settle_q, settle_d;
  satag_pkg::len_t  wr_len;

  assign wr_len = satag_pkg::eff_len(wr_data_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      o_len_q <= satag_pkg::LEN_W'(1);
      a_len_q <= satag_pkg::LEN_W'(1);
      m_len_q <= satag_pkg::LEN_W'(1);
      b_len_q <= satag_pkg::LEN_W'(1);
    end else if (wr_en_i) begin
      case (satag_pkg::reg_idx_e'(wr_idx_i))
        satag_pkg::REG_OUTER:  o_len_q <= wr_len;
        satag_pkg::REG_AXIS:   a_len_q <= wr_len;
        satag_pkg::REG_MIDDLE: m_len_q <= wr_len;
        satag_pkg::REG_BLOCK:  b_len_q <= wr_len;
        default: ;
      endcase
    end
  end

  always_comb begin
    mb_d   = satag_pkg::ADDR_W'(m_len_q) * satag_pkg::ADDR_W'(b_len_q);
    amb_d  = satag_pkg::ADDR_W'(a_len_q) * mb_q;
    step_d = mb_q - satag_pkg::ADDR_W'(b_len_q) + satag_pkg::ADDR_W'(1);
    if (wr_en_i) begin
      settle_d = satag_pkg::SETTLE_W'(satag_pkg::SETTLE_CYCLES);
    end else if (settle_q != '0) begin
      settle_d = settle_q - satag_pkg::SETTLE_W'(1);
    end else begin
      settle_d = settle_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mb_q     <= satag_pkg::ADDR_W'(1);
      amb_q    <= satag_pkg::ADDR_W'(1);
      step_q   <= satag_pkg::ADDR_W'(1);
      settle_q <= '0;
    end else begin
      mb_q     <= mb_d;
      amb_q    <= amb_d;
      step_q   <= step_d;
      settle_q <= settle_d;
    end
  end

  assign geom_o.o_len      = o_len_q;
  assign geom_o.a_len      = a_len_q;
  assign geom_o.m_len      = m_len_q;
  assign geom_o.b_len      = b_len_q;
  assign geom_o.amb_stride = amb_q;
  assign geom_o.axis_step  = step_q;
  assign settled_o         = (settle_q == '0);

endmodule

/* hw/rtl/satag_walk.sv */
// Loop counters and running address bases; forms the result of each accepted item.
// Depends on satag_pkg.
module satag_walk (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  accept_i,
  input  logic                  start_req_i,
  input  satag_pkg::geom_t      geom_i,
  output satag_pkg::res_t       res_o
);

  satag_pkg::pos_t  outer_q, outer_d, middle_q, middle_d, axis_q, axis_d, blk_q, blk_d;
  satag_pkg::addr_t obase_q, obase_d, rbase_q, rbase_d, raddr_q, raddr_d, waddr_q, waddr_d;
  logic             finished_q, finished_d;
  logic             blk_more, axis_more, mid_more, outer_more, is_last;

  always_comb begin
    blk_more   = (satag_pkg::LEN_W'(blk_q) + satag_pkg::LEN_W'(1)) < geom_i.b_len;
    axis_more  = (satag_pkg::LEN_W'(axis_q) + satag_pkg::LEN_W'(1)) < geom_i.a_len;
    mid_more   = (satag_pkg::LEN_W'(middle_q) + satag_pkg::LEN_W'(1)) < geom_i.m_len;
    outer_more = (satag_pkg::LEN_W'(outer_q) + satag_pkg::LEN_W'(1)) < geom_i.o_len;

    outer_d = outer_q;
    middle_d = middle_q;
    axis_d = axis_q;
    blk_d = blk_q;
    obase_d = obase_q;
    rbase_d = rbase_q;
    raddr_d = raddr_q;
    waddr_d = waddr_q;

    if (start_req_i) begin
      outer_d = '0;
      middle_d = '0;
      axis_d = '0;
      blk_d = '0;
      obase_d = '0;
      rbase_d = '0;
      raddr_d = '0;
      waddr_d = '0;
    end else if (!finished_q) begin
      waddr_d = waddr_q + satag_pkg::ADDR_W'(1);
      if (blk_more) begin
        blk_d = blk_q + satag_pkg::DIM_W'(1);
        raddr_d = raddr_q + satag_pkg::ADDR_W'(1);
      end else begin
        blk_d = '0;
        if (axis_more) begin
          axis_d = axis_q + satag_pkg::DIM_W'(1);
          raddr_d = raddr_q + geom_i.axis_step;
        end else begin
          axis_d = '0;
          if (mid_more) begin
            middle_d = middle_q + satag_pkg::DIM_W'(1);
            rbase_d = rbase_q + satag_pkg::ADDR_W'(geom_i.b_len);
            raddr_d = rbase_d;
          end else begin
            middle_d = '0;
            outer_d = outer_more ? outer_q + satag_pkg::DIM_W'(1) : '0;
            obase_d = obase_q + geom_i.amb_stride;
            rbase_d = obase_d;
            raddr_d = obase_d;
          end
        end
      end
    end

    is_last = ((satag_pkg::LEN_W'(outer_d) + satag_pkg::LEN_W'(1)) >= geom_i.o_len) &&
              ((satag_pkg::LEN_W'(middle_d) + satag_pkg::LEN_W'(1)) >= geom_i.m_len) &&
              ((satag_pkg::LEN_W'(axis_d) + satag_pkg::LEN_W'(1)) >= geom_i.a_len) &&
              ((satag_pkg::LEN_W'(blk_d) + satag_pkg::LEN_W'(1)) >= geom_i.b_len);

    if (start_req_i || !finished_q) begin
      finished_d         = is_last;
      res_o.source_index = raddr_d;
      res_o.dest_index   = waddr_d;
      res_o.last         = is_last;
      res_o.valid_res    = 1'b1;
    end else begin
      finished_d         = finished_q;
      res_o              = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      outer_q    <= '0;
      middle_q   <= '0;
      axis_q     <= '0;
      blk_q      <= '0;
      obase_q    <= '0;
      rbase_q    <= '0;
      raddr_q    <= '0;
      waddr_q    <= '0;
      finished_q <= 1'b1;
    end else if (accept_i) begin
      outer_q    <= outer_d;
      middle_q   <= middle_d;
      axis_q     <= axis_d;
      blk_q      <= blk_d;
      obase_q    <= obase_d;
      rbase_q    <= rbase_d;
      raddr_q    <= raddr_d;
      waddr_q    <= waddr_d;
      finished_q <= finished_d;
    end
  end

endmodule

/* hw/rtl/satag_oreg.sv */
// Output register holding one result item until the receiver takes it.
// Depends on satag_pkg.
module satag_oreg (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             load_i,
  input  satag_pkg::res_t  res_i,
  input  logic             out_ready_i,
  output logic             out_valid_o,
  output satag_pkg::res_t  res_o,
  output logic             free_o
);

  logic            valid_q, valid_d;
  satag_pkg::res_t res_q;

  assign free_o  = !valid_q || out_ready_i;
  assign valid_d = load_i ? 1'b1 : (out_ready_i ? 1'b0 : valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign res_o       = res_q;

endmodule

/* hw/rtl/single_axis_transpose_addr_gen_unit.sv */
// Top level of the single-axis transpose address generator.
// Depends on satag_pkg, satag_if, satag_cfg, satag_walk, satag_oreg.
//
// Usage:
//  - cfg_i writes outer_count (0), axis_len (1), middle_len (2), block_len (3);
//    always ready. Write only while no item is outstanding.
//  - in_i takes one item per ready cycle: start_req=1 restarts at element 0,
//    start_req=0 steps to the next element of outer x middle x axis x block order.
//  - out_o gives one result per item: source_index, dest_index, last, and
//    valid_res (0 when the pass is finished and no restart came).
//  - Latency: the result is registered, visible the cycle after the item is taken.
//  - Throughput: one item per ready cycle, set by the single counter/base update.
//  - After a config write in_i.ready is low while the stride
//    multipliers (middle*block, then axis*middle*block) settle.
//  - A stalled receiver holds the output register; a new item is taken in the
//    same cycle the held result leaves.
//  - Reset: all lengths 1, counters and bases 0, pass finished until a start.
module single_axis_transpose_addr_gen_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  satag_cfg_if.sink   cfg_i,
  satag_in_if.sink    in_i,
  satag_out_if.source out_o
);

  satag_pkg::geom_t geom;
  satag_pkg::res_t  walk_res, out_res;
  logic             settled, free, accept;

  assign cfg_i.ready = 1'b1;
  assign in_i.ready  = settled && free;
  assign accept      = in_i.valid && in_i.ready;

  satag_cfg u_cfg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (cfg_i.valid),
    .wr_idx_i  (cfg_i.index),
    .wr_data_i (cfg_i.data),
    .geom_o    (geom),
    .settled_o (settled)
  );

  satag_walk u_walk (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .start_req_i (in_i.start_req),
    .geom_i      (geom),
    .res_o       (walk_res)
  );

  satag_oreg u_oreg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (accept),
    .res_i       (walk_res),
    .out_ready_i (out_o.ready),
    .out_valid_o (out_o.valid),
    .res_o       (out_res),
    .free_o      (free)
  );

  assign out_o.source_index = out_res.source_index;
  assign out_o.dest_index   = out_res.dest_index;
  assign out_o.last         = out_res.last;
  assign out_o.valid_res    = out_res.valid_res;

endmodule
